@@ rtl/core/wftd_pkg.sv @@
// Shared types and constants for the wire-format token decoder.
// Used by every module of the decoder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wftd_pkg;

  localparam int MAX_VARINT_BYTES = 10;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int FIELD_W = 29;
  localparam int WIRE_W  = 3;
  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int LEFT_W  = 32;
  localparam int CNT_W   = 4;
  localparam int ODATA_W = 112;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIX32   = 3'd2,
    PH_FIX64   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_HOLD    = 3'd6
  } wftd_phase_t;

  typedef enum logic [2:0] {
    K_VALUE   = 3'd0,
    K_LENGTH  = 3'd1,
    K_PAYLOAD = 3'd2,
    K_GROUP   = 3'd3,
    K_ERROR   = 3'd4
  } wftd_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNTERM  = 2'd1,
    ST_ILLEGAL = 2'd2
  } wftd_status_t;

  localparam logic [WIRE_W-1:0] WT_VARINT = 3'd0;
  localparam logic [WIRE_W-1:0] WT_FIX64  = 3'd1;
  localparam logic [WIRE_W-1:0] WT_LEN    = 3'd2;
  localparam logic [WIRE_W-1:0] WT_GSTART = 3'd3;
  localparam logic [WIRE_W-1:0] WT_GEND   = 3'd4;
  localparam logic [WIRE_W-1:0] WT_FIX32  = 3'd5;

  typedef struct packed {
    wftd_kind_t          kind;
    logic [FIELD_W-1:0]  field_id;
    logic [WIRE_W-1:0]   wire_kind;
    logic [VALUE_W-1:0]  value;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last;
    wftd_status_t        status;
  } wftd_rec_t;

  typedef struct packed {
    logic      valid;
    wftd_rec_t rec;
  } wftd_push_t;

endpackage

`default_nettype wire

@@ rtl/core/wftd_front.sv @@
// Front end: accepts stream bytes, tracks the token phase and builds result records.
// Depends on wftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wftd_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [wftd_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       frame_start,
  output wftd_pkg::wftd_push_t            push
);

  wftd_pkg::wftd_phase_t phase_r, phase_nxt, ph;
  logic [wftd_pkg::VALUE_W-1:0] acc_r, acc_nxt, acc;
  logic [wftd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt, cnt_inc;
  logic [wftd_pkg::FIELD_W-1:0] field_r, field_nxt, fld;
  logic [wftd_pkg::WIRE_W-1:0]  wire_r, wire_nxt, wk;
  logic [wftd_pkg::LEFT_W-1:0]  left_r, left_nxt, left;

  logic [6:0]                   vsh;
  logic [5:0]                   fsh;
  logic [wftd_pkg::VALUE_W-1:0] vacc, facc;
  logic                         vdone, vfail, fdone, is_last;
  logic [wftd_pkg::WIRE_W-1:0]  tag_wire;

  always_comb begin
    ph   = frame_start ? wftd_pkg::PH_TAG : phase_r;
    acc  = frame_start ? '0 : acc_r;
    cnt  = frame_start ? '0 : cnt_r;
    fld  = frame_start ? '0 : field_r;
    wk   = frame_start ? '0 : wire_r;
    left = frame_start ? '0 : left_r;
  end

  always_comb begin
    cnt_inc  = cnt + 1'b1;
    vsh      = {3'b000, cnt} * 7'd7;
    fsh      = {cnt[2:0], 3'b000};
    vacc     = acc;
    if (cnt < wftd_pkg::CNT_W'(wftd_pkg::MAX_VARINT_BYTES)) begin
      vacc = acc | ({57'd0, data_byte[6:0]} << vsh);
    end
    facc     = acc;
    if (cnt < 4'd8) begin
      facc = acc | ({56'd0, data_byte} << fsh);
    end
    vdone    = !data_byte[7];
    vfail    = data_byte[7] && (cnt_inc >= wftd_pkg::CNT_W'(wftd_pkg::MAX_VARINT_BYTES));
    fdone    = (ph == wftd_pkg::PH_FIX32) ? (cnt_inc >= 4'd4) : (cnt_inc >= 4'd8);
    is_last  = (left <= 32'd1);
    tag_wire = vacc[2:0];
  end

  // Next state.
  always_comb begin
    phase_nxt = ph;
    acc_nxt   = acc;
    cnt_nxt   = cnt;
    field_nxt = fld;
    wire_nxt  = wk;
    left_nxt  = left;
    unique case (ph)
      wftd_pkg::PH_TAG: begin
        acc_nxt = vacc;
        cnt_nxt = cnt_inc;
        if (vfail) begin
          field_nxt = '0;
          wire_nxt  = '0;
          phase_nxt = wftd_pkg::PH_HOLD;
        end else if (vdone) begin
          field_nxt = vacc[31:3];
          wire_nxt  = tag_wire;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          unique case (tag_wire)
            wftd_pkg::WT_VARINT: phase_nxt = wftd_pkg::PH_VARINT;
            wftd_pkg::WT_FIX64:  phase_nxt = wftd_pkg::PH_FIX64;
            wftd_pkg::WT_LEN:    phase_nxt = wftd_pkg::PH_LENGTH;
            wftd_pkg::WT_FIX32:  phase_nxt = wftd_pkg::PH_FIX32;
            wftd_pkg::WT_GSTART,
            wftd_pkg::WT_GEND:   phase_nxt = wftd_pkg::PH_TAG;
            default:             phase_nxt = wftd_pkg::PH_HOLD;
          endcase
        end
      end
      wftd_pkg::PH_VARINT, wftd_pkg::PH_LENGTH: begin
        acc_nxt = vacc;
        cnt_nxt = cnt_inc;
        if (vfail) begin
          phase_nxt = wftd_pkg::PH_HOLD;
        end else if (vdone) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (ph == wftd_pkg::PH_VARINT) begin
            phase_nxt = wftd_pkg::PH_TAG;
          end else begin
            left_nxt  = vacc[31:0];
            phase_nxt = (vacc[31:0] == 32'd0) ? wftd_pkg::PH_TAG : wftd_pkg::PH_PAYLOAD;
          end
        end
      end
      wftd_pkg::PH_FIX32, wftd_pkg::PH_FIX64: begin
        acc_nxt = facc;
        cnt_nxt = cnt_inc;
        if (fdone) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = wftd_pkg::PH_TAG;
        end
      end
      wftd_pkg::PH_PAYLOAD: begin
        if (is_last) begin
          left_nxt  = '0;
          phase_nxt = wftd_pkg::PH_TAG;
        end else begin
          left_nxt = left - 1'b1;
        end
      end
      default: begin
        phase_nxt = wftd_pkg::PH_HOLD;
      end
    endcase
  end

  // Result record.
  always_comb begin
    push                  = '0;
    push.rec.kind         = wftd_pkg::K_VALUE;
    push.rec.status       = wftd_pkg::ST_OK;
    push.rec.field_id     = field_nxt;
    push.rec.wire_kind    = wire_nxt;
    if (accept) begin
      unique case (ph)
        wftd_pkg::PH_TAG: begin
          if (vfail) begin
            push.valid      = 1'b1;
            push.rec.kind   = wftd_pkg::K_ERROR;
            push.rec.status = wftd_pkg::ST_UNTERM;
          end else if (vdone) begin
            unique case (tag_wire)
              wftd_pkg::WT_VARINT, wftd_pkg::WT_FIX64,
              wftd_pkg::WT_LEN, wftd_pkg::WT_FIX32: push.valid = 1'b0;
              wftd_pkg::WT_GSTART, wftd_pkg::WT_GEND: begin
                push.valid    = 1'b1;
                push.rec.kind = wftd_pkg::K_GROUP;
              end
              default: begin
                push.valid      = 1'b1;
                push.rec.kind   = wftd_pkg::K_ERROR;
                push.rec.status = wftd_pkg::ST_ILLEGAL;
              end
            endcase
          end
        end
        wftd_pkg::PH_VARINT, wftd_pkg::PH_LENGTH: begin
          if (vfail) begin
            push.valid      = 1'b1;
            push.rec.kind   = wftd_pkg::K_ERROR;
            push.rec.status = wftd_pkg::ST_UNTERM;
          end else if (vdone) begin
            push.valid = 1'b1;
            if (ph == wftd_pkg::PH_VARINT) begin
              push.rec.value = vacc;
            end else begin
              push.rec.kind  = wftd_pkg::K_LENGTH;
              push.rec.value = {32'd0, vacc[31:0]};
            end
          end
        end
        wftd_pkg::PH_FIX32, wftd_pkg::PH_FIX64: begin
          if (fdone) begin
            push.valid     = 1'b1;
            push.rec.value = facc;
          end
        end
        wftd_pkg::PH_PAYLOAD: begin
          push.valid            = 1'b1;
          push.rec.kind         = wftd_pkg::K_PAYLOAD;
          push.rec.payload_byte = data_byte;
          push.rec.last         = is_last;
        end
        default: begin
          push.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wftd_pkg::PH_TAG;
      acc_r   <= '0;
      cnt_r   <= '0;
      field_r <= '0;
      wire_r  <= '0;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      field_r <= field_nxt;
      wire_r  <= wire_nxt;
      left_r  <= left_nxt;
    end
  end

  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.rec.kind == wftd_pkg::K_ERROR) |=> (phase_r == wftd_pkg::PH_HOLD))
    else $error("decoder did not hold after an error");

  a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wftd_pkg::PH_HOLD && !frame_start) |-> !push.valid)
    else $error("result produced while holding after an error");

endmodule

`default_nettype wire

@@ rtl/core/wftd_queue.sv @@
// Short record queue between the decoder front end and the output stage.
// Depends on wftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wftd_queue #(
  parameter int DEPTH = wftd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wftd_pkg::wftd_push_t      push,
  output logic                      full,
  output logic                      rd_valid,
  output wftd_pkg::wftd_rec_t       rd_rec,
  input  wire logic                 pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wftd_pkg::wftd_rec_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push.valid && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (count_r != CW'(DEPTH)))
    else $error("record written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("record read from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count did not follow a write");

endmodule

`default_nettype wire

@@ rtl/core/wftd_back.sv @@
// Back end: output register that drains the record queue onto the result stream.
// Depends on wftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wftd_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_valid,
  input  wftd_pkg::wftd_rec_t              rd_rec,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [wftd_pkg::ODATA_W-1:0]     out_tdata,
  output logic [2:0]                       out_tuser,
  output logic                             out_tlast
);

  logic                valid_r;
  wftd_pkg::wftd_rec_t rec_r;

  assign pop = rd_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= rd_rec;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rec_r.kind;
  assign out_tlast  = rec_r.last;
  assign out_tdata  = {6'd0, rec_r.status, rec_r.payload_byte, rec_r.value,
                       rec_r.wire_kind, rec_r.field_id};

endmodule

`default_nettype wire

@@ rtl/core/wire_format_token_decoder.sv @@
// Top level of the wire-format token decoder: front end, record queue, output stage.
// Depends on wftd_pkg, wftd_front, wftd_queue and wftd_back.
//
// The input stream carries one encoded byte per request in in_tdata; in_tuser marks
// a frame start, which clears the decoder and any error, and the byte begins a tag.
// Each completed value, length, payload byte, group marker or error leaves as one
// request on the output stream: out_tuser is the kind, out_tlast marks the final
// payload byte of a delimited field, and out_tdata holds the field number, wire
// type, value, payload byte and status.
// One byte is taken every cycle while the queue is not full. A result is written
// into the queue at the edge that accepts its byte and moves into the output
// register, which drives out_tvalid, once that register is empty or out_tready is
// high. Tag and value bytes that complete nothing give no result.
// A stalled receiver fills the queue of QUEUE_DEPTH records and the output register;
// in_tready falls only when the queue is full, so input and output stall apart.
// Reset (rst_n low, synchronous) empties the queue and output register and puts
// the decoder in the expect-tag phase.
`timescale 1ns / 1ps
`default_nettype none

module wire_format_token_decoder #(
  parameter int QUEUE_DEPTH = wftd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // data_byte[7:0]
  input  wire logic                          in_tuser,   // frame_start
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // field_id[28:0], wire_kind[31:29], value[95:32], payload_byte[103:96],
  // status[105:104], zero[111:106]
  output logic [wftd_pkg::ODATA_W-1:0]       out_tdata,
  output logic [2:0]                         out_tuser,  // kind
  output logic                               out_tlast
);

  logic                 accept;
  logic                 full;
  logic                 rd_valid;
  logic                 pop;
  wftd_pkg::wftd_push_t push;
  wftd_pkg::wftd_rec_t  rd_rec;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  wftd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .frame_start (in_tuser),
    .push        (push)
  );

  wftd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec),
    .pop      (pop)
  );

  wftd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (rd_valid),
    .rd_rec     (rd_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
